// ----- src/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// bds_pkg
// Shared constants, register codes and types of the box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int MAX_HALF_SIZE_DEF = 64;
    localparam int SAMPLE_WIDTH_DEF  = 32;
    localparam int GUARD_BITS        = 3;

    localparam int SLOW_HALF_MAX = 1024;
    localparam int SLOW_POS_W    = 11;
    localparam int SLOW_CMP_W    = 12;

    localparam int MODE_W     = 2;
    localparam int FAST_CFG_W = 7;
    localparam int MID_CFG_W  = 7;
    localparam int SLOW_CFG_W = 11;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_FAST = 2'd1,
        REG_MID  = 2'd2,
        REG_SLOW = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [FAST_CFG_W-1:0] fast_size;
        logic [MID_CFG_W-1:0]  mid_size;
        logic [SLOW_CFG_W-1:0] slow_size;
    } t_cfg;

    typedef struct packed {
        logic       first;
        logic       last;
        logic       field_end;
        logic [1:0] shift;
    } t_blk_info;

endpackage

// ----- src/bds_apb_regs.sv -----
// ----------------------------------------------------------------------------
// bds_apb_regs
// APB register bank holding the mode and the coarse sizes.
// ----------------------------------------------------------------------------
module bds_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bds_pkg::PADDR_W-1:0]  paddr,
    input  logic [bds_pkg::PDATA_W-1:0]  pwdata,
    output logic [bds_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bds_pkg::t_cfg                o_cfg
);
    import bds_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= '0;
            r_cfg.fast_size <= FAST_CFG_W'(1);
            r_cfg.mid_size  <= MID_CFG_W'(1);
            r_cfg.slow_size <= SLOW_CFG_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE: r_cfg.mode      <= pwdata[MODE_W-1:0];
                REG_FAST: r_cfg.fast_size <= pwdata[FAST_CFG_W-1:0];
                REG_MID:  r_cfg.mid_size  <= pwdata[MID_CFG_W-1:0];
                REG_SLOW: r_cfg.slow_size <= pwdata[SLOW_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE: prdata = PDATA_W'(r_cfg.mode);
            REG_FAST: prdata = PDATA_W'(r_cfg.fast_size);
            REG_MID:  prdata = PDATA_W'(r_cfg.mid_size);
            REG_SLOW: prdata = PDATA_W'(r_cfg.slow_size);
            default:  prdata = '0;
        endcase
    end

endmodule

// ----- src/bds_position.sv -----
// ----------------------------------------------------------------------------
// bds_position
// Fine-grid position counters; give the partial-sum address and block flags.
// ----------------------------------------------------------------------------
module bds_position #(
    parameter int MAX_HALF_SIZE = bds_pkg::MAX_HALF_SIZE_DEF,
    parameter int IDX_W         = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bds_pkg::t_cfg        i_cfg,
    input  logic                 i_adv,
    output logic [IDX_W-1:0]     o_idx,
    output bds_pkg::t_blk_info   o_info
);
    import bds_pkg::*;

    localparam int POS_W  = $clog2(2 * MAX_HALF_SIZE);
    localparam int SZ_W   = (POS_W + 1 > FAST_CFG_W) ? POS_W + 1 : FAST_CFG_W;
    localparam int CW     = SZ_W + 1;
    localparam int PROD_W = IDX_W + POS_W;

    logic [POS_W-1:0]      r_fast, r_mid, n_fast, n_mid;
    logic [SLOW_POS_W-1:0] r_slow, n_slow;
    logic [POS_W-1:0]      w_mid_eff;
    logic [SLOW_POS_W-1:0] w_slow_eff;
    logic                  w_use_mid, w_use_slow;
    logic [SZ_W-1:0]       w_fs_ext, w_ms_ext, w_fs, w_ms;
    logic [SLOW_CMP_W-1:0] w_ss_ext, w_ss;
    logic                  w_fw, w_mw, w_sw;
    logic [PROD_W-1:0]     w_prod;

    assign w_use_mid  = (i_cfg.mode != MODE_W'(0));
    assign w_use_slow = i_cfg.mode[1];
    assign w_mid_eff  = w_use_mid ? r_mid : '0;
    assign w_slow_eff = w_use_slow ? r_slow : '0;

    assign w_fs_ext = SZ_W'(i_cfg.fast_size);
    assign w_ms_ext = SZ_W'(i_cfg.mid_size);
    assign w_ss_ext = SLOW_CMP_W'(i_cfg.slow_size);

    always_comb begin
        if (w_fs_ext == '0)                      w_fs = SZ_W'(1);
        else if (w_fs_ext > SZ_W'(MAX_HALF_SIZE)) w_fs = SZ_W'(MAX_HALF_SIZE);
        else                                     w_fs = w_fs_ext;
        if (w_ms_ext == '0)                      w_ms = SZ_W'(1);
        else if (w_ms_ext > SZ_W'(MAX_HALF_SIZE)) w_ms = SZ_W'(MAX_HALF_SIZE);
        else                                     w_ms = w_ms_ext;
        if (w_ss_ext == '0)                           w_ss = SLOW_CMP_W'(1);
        else if (w_ss_ext > SLOW_CMP_W'(SLOW_HALF_MAX)) w_ss = SLOW_CMP_W'(SLOW_HALF_MAX);
        else                                          w_ss = w_ss_ext;
    end

    assign w_fw = (CW'(r_fast) + CW'(1)) >= (CW'(w_fs) << 1);
    assign w_mw = (CW'(w_mid_eff) + CW'(1)) >= (CW'(w_ms) << 1);
    assign w_sw = ((SLOW_CMP_W + 1)'(w_slow_eff) + (SLOW_CMP_W + 1)'(1))
                  >= ((SLOW_CMP_W + 1)'(w_ss) << 1);

    always_comb begin
        n_fast = w_fw ? '0 : POS_W'(r_fast + POS_W'(1));
        n_mid  = w_mid_eff;
        n_slow = w_slow_eff;
        if (w_fw && w_use_mid) begin
            n_mid = w_mw ? '0 : POS_W'(w_mid_eff + POS_W'(1));
            if (w_mw && w_use_slow) begin
                n_slow = w_sw ? '0 : SLOW_POS_W'(w_slow_eff + SLOW_POS_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= '0;
            r_mid  <= '0;
            r_slow <= '0;
        end else if (i_adv) begin
            r_fast <= n_fast;
            r_mid  <= n_mid;
            r_slow <= n_slow;
        end
    end

    assign w_prod = PROD_W'(w_mid_eff >> 1) * PROD_W'(MAX_HALF_SIZE) + PROD_W'(r_fast >> 1);
    assign o_idx  = w_prod[IDX_W-1:0];

    assign o_info.first     = !r_fast[0] && !w_mid_eff[0] && !w_slow_eff[0];
    assign o_info.last      = r_fast[0] && (!w_use_mid || w_mid_eff[0])
                              && (!w_use_slow || w_slow_eff[0]);
    assign o_info.field_end = w_fw && (!w_use_mid || w_mw) && (!w_use_slow || w_sw);
    assign o_info.shift     = w_use_slow ? 2'd3 : (w_use_mid ? 2'd2 : 2'd1);

endmodule

// ----- src/box_downsample_by_two.sv -----
// ----------------------------------------------------------------------------
// box_downsample_by_two
// Box-filter decimator by two in 1D, 2D or 3D with a partial-sum memory.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless the output stalls, set by one
//   read-modify-write of a partial sum per sample on the single-port-pair sum
//   memory. Each block result passes the sum stage into the output register.
// Reset: mode 0, all sizes 1, positions zero, pipeline empty; the sum memory
//   is not cleared, each entry is written by the first sample of its block.
module box_downsample_by_two #(
    parameter int MAX_HALF_SIZE = bds_pkg::MAX_HALF_SIZE_DEF,
    parameter int SAMPLE_WIDTH  = bds_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bds_pkg::PADDR_W-1:0]   paddr,
    input  logic [bds_pkg::PDATA_W-1:0]   pwdata,
    output logic [bds_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_average_value,
    output logic                          o_last_of_field
);
    import bds_pkg::*;

    localparam int IDX_W = (MAX_HALF_SIZE == 1) ? 1 : $clog2(MAX_HALF_SIZE * MAX_HALF_SIZE);
    localparam int DEPTH = MAX_HALF_SIZE * MAX_HALF_SIZE;
    localparam int SUM_W = SAMPLE_WIDTH + GUARD_BITS;

    t_cfg      w_cfg;
    t_blk_info w_info, r_s1_info;
    logic [IDX_W-1:0] w_idx, r_s1_idx, r_wr_idx;
    logic             w_in_xfer, w_out_free, w_s1_go, w_s1_free, w_fwd;
    logic             r_s1_vld, r_wr_vld, r_o_vld, r_o_last;
    logic signed [SUM_W-1:0] r_sums [DEPTH];
    logic signed [SUM_W-1:0] r_rd, r_wr_sum, r_s1_x, w_base, w_sum, w_avg;
    logic signed [SAMPLE_WIDTH-1:0] r_o_avg;

    bds_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bds_position #(
        .MAX_HALF_SIZE (MAX_HALF_SIZE),
        .IDX_W         (IDX_W)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_adv   (w_in_xfer),
        .o_idx   (w_idx),
        .o_info  (w_info)
    );

    assign w_out_free = !r_o_vld || i_ready;
    assign w_s1_go    = r_s1_vld && (!r_s1_info.last || w_out_free);
    assign w_s1_free  = !r_s1_vld || w_s1_go;
    assign o_ready    = w_s1_free;
    assign w_in_xfer  = i_valid && w_s1_free;

    // forward the write that landed on the edge of this entry's read
    assign w_fwd  = r_wr_vld && (r_wr_idx == r_s1_idx);
    assign w_base = w_fwd ? r_wr_sum : r_rd;
    assign w_sum  = r_s1_info.first ? r_s1_x : SUM_W'(w_base + r_s1_x);
    assign w_avg  = w_sum >>> r_s1_info.shift;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_rd <= r_sums[w_idx];
        end
        if (w_s1_go) begin
            r_sums[r_s1_idx] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_wr_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_in_xfer)    r_s1_vld <= 1'b1;
            else if (w_s1_go) r_s1_vld <= 1'b0;
            if (w_s1_go)      r_wr_vld <= 1'b1;
            if (w_s1_go && r_s1_info.last) r_o_vld <= 1'b1;
            else if (i_ready)              r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_x    <= SUM_W'(i_sample_value);
            r_s1_idx  <= w_idx;
            r_s1_info <= w_info;
        end
        if (w_s1_go) begin
            r_wr_idx <= r_s1_idx;
            r_wr_sum <= w_sum;
        end
        if (w_s1_go && r_s1_info.last) begin
            r_o_avg  <= w_avg[SAMPLE_WIDTH-1:0];
            r_o_last <= r_s1_info.field_end;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_average_value = r_o_avg;
    assign o_last_of_field = r_o_last;

    a_hold_last_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s1_info.last && r_o_vld && !i_ready |=> r_s1_vld)
        else $error("block result left stage while output was full");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && r_s1_info.last |-> w_out_free)
        else $error("output register overwritten before transfer");

    a_first_writes_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && r_s1_info.first |=> r_wr_sum == $past(r_s1_x))
        else $error("first sample of block did not open its entry");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for box_downsample_by_two. Whole fields of fine samples
// are streamed in 1D, 2D and 3D modes with random sizes and values, while both
// handshakes idle at random. A scoreboard predicts each floored block average
// and its end-of-field flag, and compares every output transfer in order.
// ----------------------------------------------------------------------------

class avg_scoreboard;
    typedef struct {
        logic signed [31:0] average;
        logic               field_end;
    } avg_result_t;

    avg_result_t        expected_q[$];
    logic signed [34:0] block_sums [4096];
    int                 fast_pos;
    int                 mid_pos;
    int                 slow_pos;
    logic [1:0]         mode;
    logic [6:0]         fast_cfg;
    logic [6:0]         mid_cfg;
    logic [10:0]        slow_cfg;
    int                 mismatches;

    function new();
        fast_pos   = 0;
        mid_pos    = 0;
        slow_pos   = 0;
        mode       = 2'd0;
        fast_cfg   = 7'd1;
        mid_cfg    = 7'd1;
        slow_cfg   = 11'd1;
        mismatches = 0;
    endfunction

    static function int clamp(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    static function int dims_of(logic [1:0] m);
        return (m == 2'd0) ? 1 : (m == 2'd1) ? 2 : 3;
    endfunction

    static function int field_len(logic [1:0] m, int f, int mi, int sl);
        int d;
        d = dims_of(m);
        return 2 * clamp(f, 64) * ((d >= 2) ? 2 * clamp(mi, 64) : 1)
               * ((d >= 3) ? 2 * clamp(sl, 1024) : 1);
    endfunction

    function void write_reg(bds_pkg::t_reg_idx idx, logic [31:0] value);
        case (idx)
            bds_pkg::REG_MODE: mode     = value[1:0];
            bds_pkg::REG_FAST: fast_cfg = value[6:0];
            bds_pkg::REG_MID:  mid_cfg  = value[6:0];
            bds_pkg::REG_SLOW: slow_cfg = value[10:0];
            default: ;
        endcase
    endfunction

    function void note_sample(logic signed [31:0] x);
        int                 d;
        int                 fs;
        int                 ms;
        int                 ss;
        int                 idx;
        bit                 fo;
        bit                 mo;
        bit                 so;
        bit                 first;
        bit                 last;
        bit                 fw;
        bit                 mw;
        bit                 sw;
        logic signed [34:0] s;
        logic signed [34:0] q;
        avg_result_t        r;
        d  = dims_of(mode);
        fs = clamp(fast_cfg, 64);
        ms = clamp(mid_cfg, 64);
        ss = clamp(slow_cfg, 1024);
        if (d < 3) slow_pos = 0;
        if (d < 2) mid_pos = 0;
        fo    = fast_pos[0];
        mo    = mid_pos[0];
        so    = slow_pos[0];
        first = !fo && (d < 2 || !mo) && (d < 3 || !so);
        last  = fo && (d < 2 || mo) && (d < 3 || so);
        idx = (mid_pos >> 1) * 64 + (fast_pos >> 1);
        if (idx >= 4096) idx = 0;
        s = first ? {{3{x[31]}}, x} : block_sums[idx] + {{3{x[31]}}, x};
        block_sums[idx] = s;
        fw = fast_pos + 1 >= 2 * fs;
        fast_pos = fw ? 0 : fast_pos + 1;
        mw = 1'b0;
        sw = 1'b0;
        if (fw && d >= 2) begin
            mw = mid_pos + 1 >= 2 * ms;
            mid_pos = mw ? 0 : mid_pos + 1;
            if (mw && d >= 3) begin
                sw = slow_pos + 1 >= 2 * ss;
                slow_pos = sw ? 0 : slow_pos + 1;
            end
        end
        if (last) begin
            q = s >>> d;
            r.average   = q[31:0];
            r.field_end = fw && (d < 2 || mw) && (d < 3 || sw);
            expected_q.push_back(r);
        end
    endfunction

    function void check_average(logic signed [31:0] average, logic field_end);
        avg_result_t r;
        if (expected_q.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: avg %h last %b", average, field_end);
            mismatches++;
        end else begin
            r = expected_q.pop_front();
            if (average !== r.average || field_end !== r.field_end) begin
                if (mismatches < 10)
                    $display("mismatch: expected avg %h last %b, got avg %h last %b",
                             r.average, r.field_end, average, field_end);
                mismatches++;
            end
        end
    endfunction
endclass

module tb;
    import bds_pkg::*;

    localparam logic [1:0] MODE_1D       = 2'd0;
    localparam logic [1:0] MODE_2D       = 2'd1;
    localparam logic [1:0] MODE_3D       = 2'd2;
    localparam logic [1:0] MODE_3D_ALIAS = 2'd3;

    localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

    localparam int RANDOM_ITEMS = 1100;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    logic signed [31:0]  i_sample_value;
    logic                o_valid;
    logic                i_ready;
    logic signed [31:0]  o_average_value;
    logic                o_last_of_field;

    avg_scoreboard sb;
    int            sample_count;
    int            stall_run;
    bit            rx_calm;

    box_downsample_by_two dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_value  (i_sample_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_average_value (o_average_value),
        .o_last_of_field (o_last_of_field)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (rx_calm) begin
            i_ready = 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            i_ready   = ($urandom_range(0, 3) != 0);
            stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_average(o_average_value, o_last_of_field);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [31:0] pick_sample(int style);
        int s;
        s = (style == 3) ? $urandom_range(0, 2) : style;
        case (s)
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return MAX_VAL;
                    1: return MIN_VAL;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $signed($urandom_range(0, 2047)) - 32'sd1024;
        endcase
    endfunction

    function automatic int pick_size(int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 4);
        if (r < 80) return 0;
        if (r < 90) return $urandom_range(5, 16);
        return $urandom_range(17, hi);
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(logic [1:0] m, int f, int mi, int sl);
        wait_idle();
        apb_write(REG_MODE, 32'(m));
        apb_write(REG_FAST, 32'(f));
        apb_write(REG_MID, 32'(mi));
        apb_write(REG_SLOW, 32'(sl));
    endtask

    task automatic send_sample(logic signed [31:0] x, int gap);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_sample_value = x;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(x);
        sample_count++;
        @(negedge i_clk);
    endtask

    task automatic run_phase(logic [1:0] m, int f, int mi, int sl, int fields);
        int  len;
        int  style;
        bit  quiet;
        configure(m, f, mi, sl);
        len     = sb.field_len(m, f, mi, sl);
        style   = $urandom_range(0, 3);
        quiet   = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        repeat (fields * len)
            send_sample(pick_sample(style), quiet ? 0 : pick_gap());
    endtask

    initial begin
        int         start;
        int         f;
        int         mi;
        int         sl;
        int         len;
        logic [1:0] m;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_sample_value = '0;
        i_ready        = 1'b0;
        stall_run      = 0;
        rx_calm        = 1'b0;
        sample_count   = 0;
        sb             = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 1D pairs at the value extremes, flooring on both signs
        configure(MODE_1D, 1, 1, 1);
        send_sample(MAX_VAL, pick_gap());
        send_sample(MAX_VAL, pick_gap());
        send_sample(MIN_VAL, pick_gap());
        send_sample(MIN_VAL, pick_gap());
        send_sample(MIN_VAL, pick_gap());
        send_sample(-32'sd1, pick_gap());
        send_sample(32'sd1, pick_gap());
        send_sample(32'sd0, pick_gap());
        send_sample(-32'sd1, pick_gap());
        send_sample(32'sd0, pick_gap());

        // mode three with zero sizes behaves as a single 2x2x2 block
        configure(MODE_3D_ALIAS, 0, 0, 0);
        repeat (8) send_sample(MIN_VAL, pick_gap());

        configure(MODE_2D, 0, 1, 1);
        repeat (4) send_sample(MAX_VAL, pick_gap());

        // shrink the fast size mid-field: the stranded position wraps
        configure(MODE_1D, 2, 1, 1);
        send_sample(MAX_VAL, pick_gap());
        send_sample(32'sd3, pick_gap());
        configure(MODE_1D, 1, 1, 1);
        send_sample(MIN_VAL, pick_gap());
        send_sample(32'sd5, pick_gap());
        send_sample(-32'sd6, pick_gap());

        // size extremes
        run_phase(MODE_1D, 127, 1, 1, 1);
        run_phase(MODE_2D, 1, 127, 1, 1);
        run_phase(MODE_3D_ALIAS, 1, 127, 1, 1);
        run_phase(MODE_3D, 64, 1, 1024, 0);

        start = sample_count;
        while (sample_count < start + RANDOM_ITEMS) begin
            do begin
                m   = 2'($urandom_range(0, 3));
                f   = pick_size(127);
                mi  = pick_size(127);
                sl  = pick_size(2047);
                len = sb.field_len(m, f, mi, sl);
            end while (len > 2048);
            run_phase(m, f, mi, sl, (len <= 256) ? $urandom_range(1, 3) : 1);
        end

        rx_calm = 1'b0;
        wait_idle();
        repeat (5) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
